>>> rtl/assert_macros.svh
// Assertion macros shared by the stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ELST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("elst assertion failed");

// Next-cycle implication, disabled while in reset.
`define ELST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("elst assertion failed");

`endif

>>> rtl/elst_pkg.sv
// Shared types and constants for the midpoint ellipse stepper.
`timescale 1ns / 1ps
`default_nettype none
package elst_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 1023;

  localparam int RAD_W   = 10;   // radius / center width
  localparam int X_W     = 11;   // step x
  localparam int Y_W     = 12;   // step y, signed
  localparam int D_W     = 48;   // decision / accumulator
  localparam int MA_W    = 34;   // multiplier operand a, signed
  localparam int MB_W    = 21;   // multiplier operand b, signed
  localparam int SQ_W    = 20;   // radius squared
  localparam int COORD_W = 12;   // plotted coordinate
  localparam int CFG_AW  = 8;
  localparam int CFG_DW  = 16;
  localparam int IN_DW   = 24;
  localparam int OUT_DW  = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [CFG_AW-1:0] REG_CENTER_X = 8'd0;
  localparam logic [CFG_AW-1:0] REG_CENTER_Y = 8'd1;

  // One issue slot of the shared multiply-accumulate unit.
  typedef struct packed {
    logic       acc;   // fold product into accumulator
    logic       clr;   // start a new sum
    logic       sub;   // subtract instead of add
    logic [1:0] sh;    // left shift of product
  } mac_op_t;

  // Point group handed to the output stage.
  typedef struct packed {
    logic        [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    logic                  fin;
  } pt_req_t;

endpackage
`default_nettype wire

>>> rtl/elst_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
`timescale 1ns / 1ps
`default_nettype none
module elst_mac (
  input  wire                              clk,
  input  wire                              rst_n,
  input  elst_pkg::mac_op_t                op,
  input  wire signed [elst_pkg::MA_W-1:0]  a,
  input  wire signed [elst_pkg::MB_W-1:0]  b,
  output logic signed [elst_pkg::D_W-1:0]  prod,
  output logic signed [elst_pkg::D_W-1:0]  acc
);
  import elst_pkg::*;

  logic signed [MA_W+MB_W-1:0] full;
  logic signed [D_W-1:0]       prod_r;
  logic signed [D_W-1:0]       acc_r;
  logic signed [D_W-1:0]       acc_nxt;
  logic signed [D_W-1:0]       shifted;
  logic signed [D_W-1:0]       base;
  mac_op_t                     op_r;

  assign full    = a * b;
  assign shifted = prod_r <<< op_r.sh;
  assign base    = op_r.clr ? '0 : acc_r;

  always_comb begin
    acc_nxt = acc_r;
    if (op_r.acc) begin
      acc_nxt = op_r.sub ? (base - shifted) : (base + shifted);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= full[D_W-1:0];
    acc_r  <= acc_nxt;
    if (!rst_n) begin
      op_r <= '0;
    end else begin
      op_r <= op;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule
`default_nettype wire

>>> rtl/elst_emit.sv
// Output stage: serializes the four symmetric points of one step.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module elst_emit (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                req_valid,
  output logic                               req_ready,
  input  elst_pkg::pt_req_t                  req,
  input  wire [elst_pkg::RAD_W-1:0]          center_x,
  input  wire [elst_pkg::RAD_W-1:0]          center_y,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // point_x [11:0], point_y [23:12], quadrant [25:24], zero pad [31:26]
  output logic [elst_pkg::OUT_DW-1:0]        out_tdata,
  output logic                               out_tlast,
  // ellipse_done [0]
  output logic                               out_tuser
);
  import elst_pkg::*;

  localparam logic [1:0] Q_PP = 2'd0;
  localparam logic [1:0] Q_MM = 2'd2;
  localparam logic [1:0] Q_PM = 2'd3;

  logic                  busy_r, busy_nxt;
  logic [1:0]            quad_r, quad_nxt;
  pt_req_t               pt_r, pt_nxt;
  logic                  out_fire;
  logic [COORD_W-1:0]    cx12, cy12, xe, ye;
  logic [COORD_W-1:0]    px, py;

  assign req_ready = !busy_r;
  assign out_fire  = out_tvalid && out_tready;

  always_comb begin
    busy_nxt = busy_r;
    quad_nxt = quad_r;
    pt_nxt   = pt_r;
    if (req_valid && req_ready) begin
      busy_nxt = 1'b1;
      quad_nxt = Q_PP;
      pt_nxt   = req;
    end else if (out_fire) begin
      if (quad_r == Q_PM) begin
        busy_nxt = 1'b0;
      end
      quad_nxt = quad_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      quad_r <= Q_PP;
    end else begin
      busy_r <= busy_nxt;
      quad_r <= quad_nxt;
    end
  end

  assign cx12 = {{(COORD_W-RAD_W){1'b0}}, center_x};
  assign cy12 = {{(COORD_W-RAD_W){1'b0}}, center_y};
  assign xe   = {{(COORD_W-X_W){1'b0}}, pt_r.x};
  assign ye   = pt_r.y;

  // +x in quadrants 0 and 3, +y in quadrants 0 and 1
  assign px = (quad_r == Q_PP || quad_r == Q_PM) ? (cx12 + xe) : (cx12 - xe);
  assign py = (quad_r == Q_MM || quad_r == Q_PM) ? (cy12 - ye) : (cy12 + ye);

  assign out_tvalid = busy_r;
  assign out_tdata  = {{(OUT_DW-2*COORD_W-2){1'b0}}, quad_r, py, px};
  assign out_tlast  = (quad_r == Q_PM);
  assign out_tuser  = pt_r.fin;

  `ELST_ASSERT_NXT(a_req_starts_q0, clk, rst_n, req_valid && req_ready,
                   out_tvalid && quad_r == Q_PP)
  `ELST_ASSERT_NXT(a_last_frees, clk, rst_n, out_fire && out_tlast, !busy_r)

endmodule
`default_nettype wire

>>> rtl/midpoint_ellipse_stepper_core.sv
// Top level of the midpoint ellipse stepper: sequencer, state and ports.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Midpoint ellipse stepper. A load beat (tuser 0) latches both radii,
// saturated to MAX_RADIUS, and runs the load sequence with no output. A step
// beat (tuser 1) before completion puts out four point beats, quadrant 0..3,
// tlast on the fourth and tuser set on all four of the final step. Every
// product runs through one shared multiplier with a registered product and
// an accumulate stage behind it, issued at most one operation per cycle by
// the sequencer: a plain step runs the region 1 test and the update, one
// entering region 2 adds the region 2 start, a region 2 step runs the check
// and the update, and a step after completion does nothing. in_tready is high
// only while the sequencer is idle; the four point beats drain from their own
// output register while the next beat is worked on. Center registers take
// effect on points emitted after the write; cfg_ready is always high.
module midpoint_ellipse_stepper_core #(
  parameter int unsigned MAX_RADIUS = elst_pkg::MAX_RADIUS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // radius_x [9:0], radius_y [19:10], zero pad [23:20]
  input  wire [elst_pkg::IN_DW-1:0]         in_tdata,
  // opcode [0]
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // point_x [11:0], point_y [23:12], quadrant [25:24], zero pad [31:26]
  output logic [elst_pkg::OUT_DW-1:0]       out_tdata,
  output logic                              out_tlast,
  // ellipse_done [0]
  output logic                              out_tuser,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [elst_pkg::CFG_AW-1:0]        cfg_addr,
  input  wire [elst_pkg::CFG_DW-1:0]        cfg_data
);
  import elst_pkg::*;

  typedef enum logic [1:0] {PH_R1, PH_R2, PH_DONE} phase_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_L0, S_L1, S_L2, S_L3, S_L4, S_LD, S_LWB,
    S_T0, S_T1, S_TD, S_TTEST,
    S_R0, S_R1, S_R2, S_R3, S_R4, S_RD, S_RWB,
    S_CHK, S_EMIT,
    S_U1, S_U2, S_U3, S_UD, S_UWB
  } state_t;

  localparam logic [1:0] SH0 = 2'd0;
  localparam logic [1:0] SH2 = 2'd2;
  localparam logic [1:0] SH3 = 2'd3;
  localparam int         MR_W = 12;

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic        [X_W-1:0]  x_r, x_nxt;
  logic signed [Y_W-1:0]  y_r, y_nxt;
  logic signed [D_W-1:0]  d_r, d_nxt;
  logic [RAD_W-1:0]      rx_r, rx_nxt, ry_r, ry_nxt;
  logic [SQ_W-1:0]       rx2_r, rx2_nxt, ry2_r, ry2_nxt;
  logic                  bx_r, bx_nxt, by_r, by_nxt, fin_r, fin_nxt;
  logic [RAD_W-1:0]      cx_r, cx_nxt, cy_r, cy_nxt;

  logic                  in_fire;
  logic [RAD_W-1:0]      rad_x_in, rad_y_in, rad_x_sat, rad_y_sat;
  logic signed [Y_W-1:0] y_dec;
  logic signed [Y_W:0]   ty;
  logic [Y_W-1:0]        tx;

  mac_op_t               mop;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [D_W-1:0]  mprod, macc;

  logic                  req_valid, req_ready;
  pt_req_t               req;

  // operand views
  logic signed [MA_W-1:0] a_rx, a_ry, a_rx2, a_ry2, a_prod;
  logic signed [MB_W-1:0] b_one, b_rx, b_ry, b_x, b_y, b_tx, b_ty, b_ry2;

  assign a_rx   = MA_W'(rx_r);
  assign a_ry   = MA_W'(ry_r);
  assign a_rx2  = MA_W'(rx2_r);
  assign a_ry2  = MA_W'(ry2_r);
  assign a_prod = mprod[MA_W-1:0];
  assign b_one  = MB_W'(1);
  assign b_rx   = MB_W'(rx_r);
  assign b_ry   = MB_W'(ry_r);
  assign b_x    = MB_W'(x_r);
  assign b_y    = MB_W'(y_r);
  assign b_tx   = MB_W'(tx);
  assign b_ty   = MB_W'(ty);
  assign b_ry2  = MB_W'(ry2_r);

  assign tx    = {x_r, 1'b1};
  assign ty    = {y_r[Y_W-1], y_r} - (Y_W+1)'(1);
  assign y_dec = y_r - Y_W'(1);

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign rad_x_in  = in_tdata[RAD_W-1:0];
  assign rad_y_in  = in_tdata[2*RAD_W-1:RAD_W];
  assign rad_x_sat = (MR_W'(rad_x_in) > MR_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_x_in;
  assign rad_y_sat = (MR_W'(rad_y_in) > MR_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_y_in;

  assign req_valid = (state_r == S_EMIT);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    d_nxt     = d_r;
    rx_nxt    = rx_r;
    ry_nxt    = ry_r;
    rx2_nxt   = rx2_r;
    ry2_nxt   = ry2_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    fin_nxt   = fin_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    mop       = '0;
    ma        = a_rx2;
    mb        = b_one;
    req.x     = x_r;
    req.y     = y_r;
    req.fin   = 1'b0;

    if (cfg_valid && cfg_ready) begin
      if (cfg_addr == REG_CENTER_X) begin
        cx_nxt = cfg_data[RAD_W-1:0];
      end else if (cfg_addr == REG_CENTER_Y) begin
        cy_nxt = cfg_data[RAD_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == OP_LOAD) begin
            rx_nxt    = rad_x_sat;
            ry_nxt    = rad_y_sat;
            x_nxt     = '0;
            y_nxt     = Y_W'(rad_y_sat);
            phase_nxt = PH_R1;
            state_nxt = S_L0;
          end else if (phase_r == PH_R1) begin
            state_nxt = S_T0;
          end else if (phase_r == PH_R2) begin
            state_nxt = S_CHK;
          end
        end
      end
      // load: rx^2, ry^2, then d = 4ry^2 - 4rx^2*ry + rx^2
      S_L0: begin
        ma = a_rx; mb = b_rx;
        state_nxt = S_L1;
      end
      S_L1: begin
        rx2_nxt = mprod[SQ_W-1:0];
        ma = a_ry; mb = b_ry;
        state_nxt = S_L2;
      end
      S_L2: begin
        ry2_nxt = mprod[SQ_W-1:0];
        ma = a_rx2; mb = b_ry;
        mop = '{acc: 1'b1, clr: 1'b1, sub: 1'b1, sh: SH2};
        state_nxt = S_L3;
      end
      S_L3: begin
        ma = a_ry2; mb = b_one;
        mop = '{acc: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH2};
        state_nxt = S_L4;
      end
      S_L4: begin
        ma = a_rx2; mb = b_one;
        mop = '{acc: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH0};
        state_nxt = S_LD;
      end
      S_LD: state_nxt = S_LWB;
      S_LWB: begin
        d_nxt     = macc;
        state_nxt = S_IDLE;
      end
      // region 1 test: ry^2*x - rx^2*y <= 0
      S_T0: begin
        ma = a_ry2; mb = b_x;
        mop = '{acc: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH0};
        state_nxt = S_T1;
      end
      S_T1: begin
        ma = a_rx2; mb = b_y;
        mop = '{acc: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH0};
        state_nxt = S_TD;
      end
      S_TD: state_nxt = S_TTEST;
      S_TTEST: begin
        if (!y_r[Y_W-1] && (macc[D_W-1] || macc == '0)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_R0;
        end
      end
      // region 2 start: ry^2*tx^2 + 4rx^2*ty^2 - 4rx^2*ry^2
      S_R0: begin
        ma = a_ry2; mb = b_tx;
        state_nxt = S_R1;
      end
      S_R1: begin
        ma = a_prod; mb = b_tx;
        mop = '{acc: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH0};
        state_nxt = S_R2;
      end
      S_R2: begin
        ma = a_rx2; mb = b_ty;
        state_nxt = S_R3;
      end
      S_R3: begin
        ma = a_prod; mb = b_ty;
        mop = '{acc: 1'b1, clr: 1'b0, sub: 1'b0, sh: SH2};
        state_nxt = S_R4;
      end
      S_R4: begin
        ma = a_rx2; mb = b_ry2;
        mop = '{acc: 1'b1, clr: 1'b0, sub: 1'b1, sh: SH2};
        state_nxt = S_RD;
      end
      S_RD: state_nxt = S_RWB;
      S_RWB: begin
        d_nxt     = macc;
        phase_nxt = PH_R2;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (y_r[Y_W-1]) begin
          phase_nxt = PH_DONE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      // hand off current point, then move x/y and pick the update terms
      S_EMIT: begin
        if (phase_r == PH_R1) begin
          req.fin = !d_r[D_W-1] && y_dec[Y_W-1];
        end else begin
          req.fin = y_dec[Y_W-1];
        end
        if (req_ready) begin
          fin_nxt = req.fin;
          if (phase_r == PH_R1) begin
            x_nxt  = x_r + X_W'(1);
            bx_nxt = 1'b1;
            by_nxt = !d_r[D_W-1];
            if (!d_r[D_W-1]) begin
              y_nxt = y_dec;
            end
          end else begin
            y_nxt  = y_dec;
            by_nxt = 1'b1;
            if (!d_r[D_W-1] && d_r != '0) begin
              bx_nxt = 1'b0;
            end else begin
              bx_nxt = 1'b1;
              x_nxt  = x_r + X_W'(1);
            end
          end
          state_nxt = S_U1;
        end
      end
      S_U1: begin
        ma = (phase_r == PH_R1) ? a_ry2 : a_rx2; mb = b_one;
        mop = '{acc: 1'b1, clr: 1'b1, sub: 1'b0, sh: SH2};
        state_nxt = S_U2;
      end
      S_U2: begin
        ma = a_ry2; mb = b_x;
        mop = '{acc: bx_r, clr: 1'b0, sub: 1'b0, sh: SH3};
        state_nxt = S_U3;
      end
      S_U3: begin
        ma = a_rx2; mb = b_y;
        mop = '{acc: by_r, clr: 1'b0, sub: 1'b1, sh: SH3};
        state_nxt = S_UD;
      end
      S_UD: state_nxt = S_UWB;
      S_UWB: begin
        d_nxt = d_r + macc;
        if (fin_r) begin
          phase_nxt = PH_DONE;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    d_r   <= d_nxt;
    rx_r  <= rx_nxt;
    ry_r  <= ry_nxt;
    rx2_r <= rx2_nxt;
    ry2_r <= ry2_nxt;
    bx_r  <= bx_nxt;
    by_r  <= by_nxt;
    fin_r <= fin_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DONE;
      cx_r    <= RAD_W'(320);
      cy_r    <= RAD_W'(240);
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
    end
  end

  elst_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mop),
    .a     (ma),
    .b     (mb),
    .prod  (mprod),
    .acc   (macc)
  );

  elst_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .center_x   (cx_r),
    .center_y   (cy_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `ELST_ASSERT_IMP(a_emit_live, clk, rst_n, req_valid, phase_r != PH_DONE)
  `ELST_ASSERT_NXT(a_load_restarts, clk, rst_n, in_fire && in_tuser == OP_LOAD,
                   phase_r == PH_R1 && x_r == '0 && state_r == S_L0)
  `ELST_ASSERT_NXT(a_done_step_idle, clk, rst_n,
                   in_fire && in_tuser == OP_STEP && phase_r == PH_DONE,
                   state_r == S_IDLE && phase_r == PH_DONE)

endmodule
`default_nettype wire
